@@ hdl/tcb_pkg.sv @@
// tcb_pkg: shared constants, types and helpers of the text console buffer
// no dependencies
package tcb_pkg;

  localparam int ROWS   = 32;
  localparam int COLS   = 80;
  localparam int CELLS  = ROWS * COLS;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROW_WX = ROW_W + 1;
  localparam int COL_W  = $clog2(COLS + 1);
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ARG_W  = 8;
  localparam int CMD_W  = 2;
  localparam int S_DATA_W = 3 * ARG_W;
  localparam int M_DATA_W = ((CHAR_W + COL_W + ROW_W + 7) / 8) * 8;

  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_WRITE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // physical cell address of a logical row and column under a top-row offset
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] top);
    logic [ROW_W:0]   sum;
    logic [ROW_W-1:0] prow;
    sum = {1'b0, row} + {1'b0, top};
    if (sum >= ROW_WX'(ROWS)) begin
      sum = sum - ROW_WX'(ROWS);
    end
    prow = sum[ROW_W-1:0];
    return ADDR_W'(prow) * ADDR_W'(COLS) + ADDR_W'(col);
  endfunction

endpackage

@@ hdl/tcb_screen_ram.sv @@
// tcb_screen_ram: character store, one write and one registered read port
// depends on tcb_pkg
module tcb_screen_ram (
  input  logic                         clk,
  input  tcb_pkg::mem_req_t            req,
  output logic [tcb_pkg::CHAR_W-1:0]   rdata
);

  logic [tcb_pkg::CHAR_W-1:0] mem [tcb_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ hdl/tcb_ctrl.sv @@
// tcb_ctrl: command sequencer, cursor and scroll state, blanking sweeps, result register
// depends on tcb_pkg
module tcb_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tcb_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic [tcb_pkg::CMD_W-1:0]      s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tcb_pkg::M_DATA_W-1:0]   m_tdata,
  output tcb_pkg::mem_req_t              mem_req,
  input  logic [tcb_pkg::CHAR_W-1:0]     rdata
);

  tcb_pkg::state_t state, state_next;

  logic [tcb_pkg::COL_W-1:0]  cur_col;
  logic [tcb_pkg::ROW_W-1:0]  cur_row;
  logic [tcb_pkg::ROW_W-1:0]  top;
  logic [tcb_pkg::ADDR_W-1:0] cnt;
  logic [tcb_pkg::ADDR_W-1:0] last_addr;
  logic                       wr_pend;
  logic                       resp_pend;
  logic                       rd_hit;
  logic [tcb_pkg::ADDR_W-1:0] wr_addr;
  logic [tcb_pkg::CHAR_W-1:0] wr_data;
  logic [tcb_pkg::CHAR_W-1:0] o_cell;
  logic [tcb_pkg::COL_W-1:0]  o_col;
  logic [tcb_pkg::ROW_W-1:0]  o_row;

  tcb_pkg::cmd_t              cmd;
  logic [tcb_pkg::ARG_W-1:0]  ch, ca, ra;
  logic                       accept, out_free, sweep_done;
  logic                       is_nl, col_wrap, need_nl, do_scroll;
  logic                       ca_ok, ra_ok, rd_ok;
  logic [tcb_pkg::ROW_W:0]    row_inc, top_inc;
  logic [tcb_pkg::ROW_W-1:0]  row_new, top_new;
  logic [tcb_pkg::COL_W-1:0]  col_eff, col_new;
  logic [tcb_pkg::ADDR_W-1:0] put_addr, rd_addr, blank_base;

  assign cmd = tcb_pkg::cmd_t'(s_tuser);
  assign ch  = s_tdata[tcb_pkg::ARG_W-1:0];
  assign ca  = s_tdata[2*tcb_pkg::ARG_W-1:tcb_pkg::ARG_W];
  assign ra  = s_tdata[3*tcb_pkg::ARG_W-1:2*tcb_pkg::ARG_W];

  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign sweep_done = (cnt == last_addr);

  // cursor movement for put character
  always_comb begin
    is_nl     = (ch == tcb_pkg::NEWLINE_CHAR);
    col_wrap  = (cur_col >= tcb_pkg::COL_W'(tcb_pkg::COLS));
    need_nl   = is_nl || col_wrap;
    row_inc   = {1'b0, cur_row} + 1'b1;
    do_scroll = need_nl && (row_inc >= tcb_pkg::ROW_WX'(tcb_pkg::ROWS));
    if (!need_nl) begin
      row_new = cur_row;
    end else if (do_scroll) begin
      row_new = tcb_pkg::ROW_W'(tcb_pkg::ROWS - 1);
    end else begin
      row_new = row_inc[tcb_pkg::ROW_W-1:0];
    end
    col_eff = need_nl ? '0 : cur_col;
    col_new = is_nl ? '0 : col_eff + 1'b1;
    top_inc = {1'b0, top} + 1'b1;
    if (!do_scroll) begin
      top_new = top;
    end else if (top_inc >= tcb_pkg::ROW_WX'(tcb_pkg::ROWS)) begin
      top_new = '0;
    end else begin
      top_new = top_inc[tcb_pkg::ROW_W-1:0];
    end
    put_addr   = tcb_pkg::phys_addr(row_new, col_eff, top_new);
    blank_base = tcb_pkg::ADDR_W'(top) * tcb_pkg::ADDR_W'(tcb_pkg::COLS);
    ca_ok      = ({1'b0, ca} < 9'(tcb_pkg::COLS));
    ra_ok      = ({1'b0, ra} < 9'(tcb_pkg::ROWS));
    rd_ok      = ca_ok && ra_ok;
    rd_addr    = tcb_pkg::phys_addr(tcb_pkg::ROW_W'(ra), tcb_pkg::COL_W'(ca), top);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            tcb_pkg::CMD_PUT: begin
              if (do_scroll) begin
                state_next = tcb_pkg::ST_SWEEP;
              end else if (is_nl) begin
                state_next = tcb_pkg::ST_RESP;
              end else begin
                state_next = tcb_pkg::ST_WRITE;
              end
            end
            tcb_pkg::CMD_CLEAR: state_next = tcb_pkg::ST_SWEEP;
            default:            state_next = tcb_pkg::ST_RESP;
          endcase
        end
      end
      tcb_pkg::ST_SWEEP: begin
        if (sweep_done) begin
          if (wr_pend) begin
            state_next = tcb_pkg::ST_WRITE;
          end else if (resp_pend) begin
            state_next = tcb_pkg::ST_RESP;
          end else begin
            state_next = tcb_pkg::ST_IDLE;
          end
        end
      end
      tcb_pkg::ST_WRITE: state_next = tcb_pkg::ST_RESP;
      tcb_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = tcb_pkg::ST_IDLE;
        end
      end
      default: state_next = tcb_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready      = (state == tcb_pkg::ST_IDLE);
    mem_req.we    = 1'b0;
    mem_req.waddr = cnt;
    mem_req.wdata = tcb_pkg::SPACE_CHAR;
    mem_req.re    = 1'b0;
    mem_req.raddr = rd_addr;
    unique case (state)
      tcb_pkg::ST_IDLE:  mem_req.re = accept && (cmd == tcb_pkg::CMD_READ) && rd_ok;
      tcb_pkg::ST_SWEEP: mem_req.we = 1'b1;
      tcb_pkg::ST_WRITE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = wr_addr;
        mem_req.wdata = wr_data;
      end
      default: mem_req.we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcb_pkg::ST_SWEEP;
      cur_col   <= '0;
      cur_row   <= '0;
      top       <= '0;
      cnt       <= '0;
      last_addr <= tcb_pkg::ADDR_W'(tcb_pkg::CELLS - 1);
      wr_pend   <= 1'b0;
      resp_pend <= 1'b0;
      rd_hit    <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tcb_pkg::ST_SWEEP) begin
        cnt <= cnt + 1'b1;
      end
      if (state == tcb_pkg::ST_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        rd_hit    <= 1'b0;
        wr_pend   <= 1'b0;
        resp_pend <= 1'b1;
        unique case (cmd)
          tcb_pkg::CMD_PUT: begin
            cur_col   <= col_new;
            cur_row   <= row_new;
            top       <= top_new;
            wr_pend   <= !is_nl;
            cnt       <= blank_base;
            last_addr <= blank_base + tcb_pkg::ADDR_W'(tcb_pkg::COLS - 1);
          end
          tcb_pkg::CMD_SET: begin
            cur_col <= ca_ok ? tcb_pkg::COL_W'(ca) : '0;
            cur_row <= ra_ok ? tcb_pkg::ROW_W'(ra) : '0;
          end
          tcb_pkg::CMD_CLEAR: begin
            cur_col   <= '0;
            cur_row   <= '0;
            top       <= '0;
            cnt       <= '0;
            last_addr <= tcb_pkg::ADDR_W'(tcb_pkg::CELLS - 1);
          end
          tcb_pkg::CMD_READ: rd_hit <= rd_ok;
          default: rd_hit <= 1'b0;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      wr_addr <= put_addr;
      wr_data <= ch;
    end
    if (state == tcb_pkg::ST_RESP && out_free) begin
      o_cell <= rd_hit ? rdata : '0;
      o_col  <= cur_col;
      o_row  <= cur_row;
    end
  end

  assign m_tdata = tcb_pkg::M_DATA_W'({o_row, o_col, o_cell});

endmodule

@@ hdl/text_console_buffer_top.sv @@
// text_console_buffer_top: character-cell console, each request yields one response
// set cursor, read cell, newline: straight to the response state; other put: through a write state
// a put that scrolls first sweeps the old top row to spaces; clear sweeps the whole screen
// only one request is in flight: the next is taken only once the last response is issued
// synchronous reset homes the cursor, then a clearing pass fills every cell with spaces
// depends on tcb_pkg, tcb_ctrl, tcb_screen_ram
module text_console_buffer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tcb_pkg::S_DATA_W-1:0]  s_tdata,  // char_code, col_arg, row_arg
  input  logic [tcb_pkg::CMD_W-1:0]     s_tuser,  // cmd
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tcb_pkg::M_DATA_W-1:0]  m_tdata   // cell_char, cursor_col, cursor_row
);

  tcb_pkg::mem_req_t          mem_req;
  logic [tcb_pkg::CHAR_W-1:0] rdata;

  tcb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .mem_req  (mem_req),
    .rdata    (rdata)
  );

  tcb_screen_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

endmodule

@@ hdl/tcb_checker.sv @@
// tcb_checker: port-level checks of the text console buffer, bound to the top level
// depends on tcb_pkg and text_console_buffer_top
module tcb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [tcb_pkg::S_DATA_W-1:0]  s_tdata,
  input logic [tcb_pkg::CMD_W-1:0]     s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tcb_pkg::M_DATA_W-1:0]  m_tdata
);

  logic [tcb_pkg::COL_W-1:0] o_col;
  logic [tcb_pkg::ROW_W-1:0] o_row;

  assign o_col = m_tdata[tcb_pkg::CHAR_W+tcb_pkg::COL_W-1:tcb_pkg::CHAR_W];
  assign o_row = m_tdata[tcb_pkg::CHAR_W+tcb_pkg::COL_W+tcb_pkg::ROW_W-1:
                         tcb_pkg::CHAR_W+tcb_pkg::COL_W];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("response changed while stalled");

  a_cursor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> o_col <= tcb_pkg::COL_W'(tcb_pkg::COLS)
                 && {1'b0, o_row} < tcb_pkg::ROW_WX'(tcb_pkg::ROWS))
    else $error("cursor out of range");

  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  a_reset_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready && !m_tvalid)
    else $error("not clearing after reset");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == tcb_pkg::CMD_CLEAR |=> !s_tready ##1 !s_tready)
    else $error("clear did not sweep");

endmodule

bind text_console_buffer_top tcb_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/tb_text_console_buffer_top.sv @@
// tb_text_console_buffer_top: self-checking bench for the text console buffer
// directed and random console commands, a shadow screen predicts each reply
// depends on tcb_pkg and text_console_buffer_top
module tb_text_console_buffer_top;
  import tcb_pkg::*;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1800;

  typedef struct {
    logic [CHAR_W-1:0] cell_char;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
  } console_reply_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [CMD_W-1:0]    s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;

  console_reply_t    console_replies[$];
  logic [CHAR_W-1:0] shadow_cells [CELLS];
  int unsigned       shadow_col;
  int unsigned       shadow_row;
  int unsigned       shadow_top;
  int                mismatch_count = 0;
  int                cycle_count = 0;
  bit                gaps_on;
  bit                hold_off_req;

  text_console_buffer_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void blank_shadow();
    for (int i = 0; i < CELLS; i++) begin
      shadow_cells[i] = SPACE_CHAR;
    end
    shadow_col = 0;
    shadow_row = 0;
    shadow_top = 0;
  endfunction

  function automatic int unsigned shadow_addr(input int unsigned row, input int unsigned col);
    return ((row + shadow_top) % ROWS) * COLS + col;
  endfunction

  // new line, scrolling the screen up when the cursor leaves the last row
  function automatic void shadow_line_feed();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= ROWS) begin
      for (int c = 0; c < COLS; c++) begin
        shadow_cells[shadow_top * COLS + c] = SPACE_CHAR;
      end
      shadow_top = (shadow_top + 1) % ROWS;
      shadow_row = ROWS - 1;
    end
  endfunction

  function automatic console_reply_t predict_console_reply(input cmd_t cmd,
                                                           input logic [7:0] ch,
                                                           input logic [7:0] col,
                                                           input logic [7:0] row);
    console_reply_t reply;
    reply.cell_char = '0;
    case (cmd)
      CMD_PUT: begin
        if (ch == NEWLINE_CHAR) begin
          shadow_line_feed();
        end else begin
          if (shadow_col >= COLS) begin
            shadow_line_feed();
          end
          shadow_cells[shadow_addr(shadow_row, shadow_col)] = ch;
          shadow_col++;
        end
      end
      CMD_SET: begin
        shadow_col = (col < COLS) ? 32'(col) : 0;
        shadow_row = (row < ROWS) ? 32'(row) : 0;
      end
      CMD_CLEAR: begin
        blank_shadow();
      end
      default: begin
        if (col < COLS && row < ROWS) begin
          reply.cell_char = shadow_cells[shadow_addr(32'(row), 32'(col))];
        end
      end
    endcase
    reply.cursor_col = COL_W'(shadow_col);
    reply.cursor_row = ROW_W'(shadow_row);
    return reply;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!gaps_on) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(10, 40);
    end
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // entered at a falling edge, returns at a falling edge with the request dropped
  task automatic issue_command(input cmd_t cmd, input logic [7:0] ch,
                               input logic [7:0] col, input logic [7:0] row);
    int gap;
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = {row, col, ch};
    do @(posedge clk); while (!s_tready);
    console_replies.push_back(predict_console_reply(cmd, ch, col, row));
    @(negedge clk);
    s_tvalid = 1'b0;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
  endtask

  initial begin : reply_sink
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : reply_check
    console_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (console_replies.size() == 0) begin
        $display("%0t: reply with nothing expected, got %h", $time, m_tdata);
        mismatch_count++;
      end else begin
        want = console_replies.pop_front();
        check_field("cell_char", 32'(want.cell_char), 32'(m_tdata[CHAR_W-1:0]));
        check_field("cursor_col", 32'(want.cursor_col), 32'(m_tdata[CHAR_W +: COL_W]));
        check_field("cursor_row", 32'(want.cursor_row),
                    32'(m_tdata[CHAR_W + COL_W +: ROW_W]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_put_and_read();
    issue_command(CMD_READ, 8'h00, 8'd0, 8'd0);
    issue_command(CMD_PUT, 8'h41, 8'd0, 8'd0);
    issue_command(CMD_PUT, 8'h00, 8'hff, 8'hff);
    issue_command(CMD_PUT, 8'hff, 8'd0, 8'd0);
    issue_command(CMD_READ, 8'hff, 8'd1, 8'd0);
    issue_command(CMD_READ, 8'h00, 8'd2, 8'd0);
  endtask

  task automatic test_cursor_limits();
    issue_command(CMD_SET, 8'h00, 8'd79, 8'd31);
    issue_command(CMD_READ, 8'h00, 8'd79, 8'd31);
    issue_command(CMD_SET, 8'h00, 8'd80, 8'd32);
    issue_command(CMD_SET, 8'h00, 8'd255, 8'd5);
    issue_command(CMD_SET, 8'h00, 8'd3, 8'd255);
    issue_command(CMD_READ, 8'h00, 8'd80, 8'd0);
    issue_command(CMD_READ, 8'h00, 8'd0, 8'd32);
    issue_command(CMD_READ, 8'h00, 8'd255, 8'd255);
  endtask

  task automatic test_wrap_and_scroll();
    issue_command(CMD_SET, 8'h00, 8'd78, 8'd31);
    issue_command(CMD_PUT, 8'h78, 8'd0, 8'd0);
    issue_command(CMD_PUT, 8'h79, 8'd0, 8'd0);
    issue_command(CMD_PUT, 8'h7a, 8'd0, 8'd0);
    issue_command(CMD_READ, 8'h00, 8'd79, 8'd30);
    issue_command(CMD_PUT, NEWLINE_CHAR, 8'd0, 8'd0);
    issue_command(CMD_READ, 8'h00, 8'd0, 8'd30);
  endtask

  task automatic test_clear();
    issue_command(CMD_CLEAR, 8'h55, 8'd7, 8'd9);
    issue_command(CMD_READ, 8'h00, 8'd1, 8'd0);
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 2) begin
        issue_command(CMD_READ, 8'h00, 8'(i), 8'd0);
      end else begin
        issue_command(CMD_PUT, 8'(8'h30 + i), 8'd0, 8'd0);
      end
    end
  endtask

  task automatic test_random_traffic(input int item_target);
    int   sent;
    int   roll;
    int   burst;
    cmd_t cmd;
    logic [7:0] ch;
    sent = 0;
    while (sent < item_target) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        // a run of text, often on the bottom rows so that it wraps and scrolls
        issue_command(CMD_SET, 8'($urandom_range(0, 255)), 8'($urandom_range(0, COLS - 1)),
                      ($urandom_range(0, 1) != 0) ? 8'(ROWS - 1 - $urandom_range(0, 2))
                                                  : 8'($urandom_range(0, ROWS - 1)));
        burst = $urandom_range(1, 100);
        for (int i = 0; i < burst; i++) begin
          roll = $urandom_range(0, 99);
          if (roll < 8) begin
            ch = NEWLINE_CHAR;
          end else if (roll < 14) begin
            ch = 8'($urandom_range(0, 255));
          end else begin
            ch = 8'($urandom_range(8'h20, 8'h7e));
          end
          issue_command(CMD_PUT, ch, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        sent += burst + 1;
      end else if (roll < 85) begin
        burst = $urandom_range(1, 12);
        for (int i = 0; i < burst; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            issue_command(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
          end else begin
            issue_command(CMD_READ, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, COLS - 1)), 8'($urandom_range(0, ROWS - 1)));
          end
        end
        sent += burst;
      end else if (roll < 98) begin
        // noise: any field value, any command
        burst = $urandom_range(1, 10);
        for (int i = 0; i < burst; i++) begin
          roll = $urandom_range(0, 39);
          if (roll == 0) begin
            cmd = CMD_CLEAR;
          end else if (roll < 14) begin
            cmd = CMD_PUT;
          end else if (roll < 27) begin
            cmd = CMD_SET;
          end else begin
            cmd = CMD_READ;
          end
          issue_command(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
        end
        sent += burst;
      end else begin
        issue_command(CMD_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        sent += 1;
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = CMD_PUT;
    gaps_on      = 1'b0;
    hold_off_req = 1'b0;
    blank_shadow();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_put_and_read();
    test_cursor_limits();
    gaps_on = 1'b1;
    test_wrap_and_scroll();
    test_clear();
    test_backpressure();
    test_random_traffic(RANDOM_ITEMS);

    while (console_replies.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/tcb_pkg.sv
hdl/tcb_screen_ram.sv
hdl/tcb_ctrl.sv
hdl/text_console_buffer_top.sv
hdl/tcb_checker.sv
tb/tb_text_console_buffer_top.sv
